// ===== hdl/lsuwb_pkg.sv =====
// ----------------------------------------------------------------------------
// Load/store unit package
// Shared types, operation codes and widths for the load/store unit.
// ----------------------------------------------------------------------------
package lsuwb_pkg;

  localparam int unsigned DATA_W      = 64;
  localparam int unsigned ACTION_W    = 4;
  localparam int unsigned FIELD_IDX_W = 6;
  // Wide enough for the largest register file the unit supports.
  localparam int unsigned RF_IDX_W    = 8;
  localparam int unsigned WORD_BYTES  = 8;
  localparam int unsigned BYTE_SEL_W  = 3;

  localparam logic [ACTION_W-1:0] ACT_LOAD       = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_AI    = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_LOAD_AO    = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_CLOAD      = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_CLOAD_AI   = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_CLOAD_AO   = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_LOAD_I     = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_STORE      = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_STORE_AI   = 4'd8;
  localparam logic [ACTION_W-1:0] ACT_STORE_AO   = 4'd9;
  localparam logic [ACTION_W-1:0] ACT_CSTORE     = 4'd10;
  localparam logic [ACTION_W-1:0] ACT_CSTORE_AI  = 4'd11;
  localparam logic [ACTION_W-1:0] ACT_CSTORE_AO  = 4'd12;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LOADI,
    KIND_LOAD,
    KIND_STORE
  } op_kind_e;

  typedef enum logic [1:0] {
    MODE_REG,
    MODE_IMM,
    MODE_SUM
  } addr_mode_e;

  // One classified operation, handed from the front end to the back end.
  typedef struct packed {
    op_kind_e                kind;
    logic                    is_byte;
    logic                    fault;
    logic [RF_IDX_W-1:0]     rf_idx;
    logic [FIELD_IDX_W-1:0]  wr_index;
    logic [DATA_W-1:0]       addr;
    logic [DATA_W-1:0]       data;
  } op_t;

  typedef struct packed {
    logic                en;
    logic [RF_IDX_W-1:0] idx;
    logic [DATA_W-1:0]   data;
  } rf_wr_t;

endpackage

// ===== hdl/load_store_unit_word_byte.sv =====
// ----------------------------------------------------------------------------
// Load/store unit, word and byte
// Executes one load/store instruction word at a time against a register file
// and a byte-addressed memory; a front end decodes and forms the address, a
// back end performs the memory access and write-back.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid_i/in_stall_o  action, base_reg, offset_reg,
//                                              data_reg, immediate
//   out      output     out_valid_o/out_stall_i fault, reg_written,
//                                              written_index, written_value,
//                                              access_address
//
// One word at a time: the next word is taken only once the previous one has
// left the queue and the back end. A load takes longer than a store of the
// same size and a word access longer than a byte access; loadI, faulting and
// unused operations are quickest. The memory has a single byte port, so a word moves one byte per cycle.
// Reset clears the register file through per-entry valid bits; the memory is
// not cleared. A stalled result waits in the output register while the next
// word is already taken and worked on.
// ----------------------------------------------------------------------------
module load_store_unit_word_byte #(
  parameter int unsigned REG_COUNT = 64,
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lsuwb_pkg::ACTION_W-1:0]      action_i,
  input  logic [lsuwb_pkg::FIELD_IDX_W-1:0]   base_reg_i,
  input  logic [lsuwb_pkg::FIELD_IDX_W-1:0]   offset_reg_i,
  input  logic [lsuwb_pkg::FIELD_IDX_W-1:0]   data_reg_i,
  input  logic signed [lsuwb_pkg::DATA_W-1:0] immediate_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                fault_o,
  output logic                                reg_written_o,
  output logic [lsuwb_pkg::FIELD_IDX_W-1:0]   written_index_o,
  output logic [lsuwb_pkg::DATA_W-1:0]        written_value_o,
  output logic [lsuwb_pkg::DATA_W-1:0]        access_address_o
);

  localparam int unsigned RIW = $clog2(REG_COUNT);

  logic                          q_push, q_pop, q_empty, q_full, back_idle;
  lsuwb_pkg::op_t                q_push_data, q_head;
  logic                          rf_rd_en;
  logic [RIW-1:0]                rf_idx_a, rf_idx_b;
  logic [lsuwb_pkg::DATA_W-1:0]  rf_data_a, rf_data_b;
  lsuwb_pkg::rf_wr_t             rf_wr;

  lsuwb_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (rf_rd_en),
    .rd_idx_a_i  (rf_idx_a),
    .rd_idx_b_i  (rf_idx_b),
    .rd_data_a_o (rf_data_a),
    .rd_data_b_o (rf_data_b),
    .wr_i        (rf_wr)
  );

  lsuwb_front #(
    .REG_COUNT(REG_COUNT),
    .MEM_BYTES(MEM_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .base_reg_i   (base_reg_i),
    .offset_reg_i (offset_reg_i),
    .data_reg_i   (data_reg_i),
    .immediate_i  (immediate_i),
    .back_idle_i  (back_idle),
    .q_empty_i    (q_empty),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_push_data),
    .rf_rd_en_o   (rf_rd_en),
    .rf_idx_a_o   (rf_idx_a),
    .rf_idx_b_o   (rf_idx_b),
    .rf_data_a_i  (rf_data_a),
    .rf_data_b_i  (rf_data_b)
  );

  lsuwb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  lsuwb_back #(
    .MEM_BYTES(MEM_BYTES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_data_i         (q_head),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .back_idle_o      (back_idle),
    .rf_wr_o          (rf_wr),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .fault_o          (fault_o),
    .reg_written_o    (reg_written_o),
    .written_index_o  (written_index_o),
    .written_value_o  (written_value_o),
    .access_address_o (access_address_o)
  );

endmodule

// ===== hdl/lsuwb_regfile.sv =====
// ----------------------------------------------------------------------------
// Load/store unit register file
// Two registered read ports and one write port; entries read as zero until
// they are first written after reset.
// ----------------------------------------------------------------------------
module lsuwb_regfile #(
  parameter int unsigned REG_COUNT = 64,
  localparam int unsigned RIW = $clog2(REG_COUNT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [RIW-1:0]                rd_idx_a_i,
  input  logic [RIW-1:0]                rd_idx_b_i,
  output logic [lsuwb_pkg::DATA_W-1:0]  rd_data_a_o,
  output logic [lsuwb_pkg::DATA_W-1:0]  rd_data_b_o,
  input  lsuwb_pkg::rf_wr_t             wr_i
);

  logic [lsuwb_pkg::DATA_W-1:0] rf_q [REG_COUNT];
  logic [REG_COUNT-1:0]         valid_q;
  logic [lsuwb_pkg::DATA_W-1:0] rdat_a_q, rdat_b_q;
  logic                         rval_a_q, rval_b_q;
  logic [RIW-1:0]               wr_idx;

  assign wr_idx = wr_i.idx[RIW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rval_a_q <= 1'b0;
      rval_b_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rval_a_q <= valid_q[rd_idx_a_i];
        rval_b_q <= valid_q[rd_idx_b_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      rf_q[wr_idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rdat_a_q <= rf_q[rd_idx_a_i];
      rdat_b_q <= rf_q[rd_idx_b_i];
    end
  end

  assign rd_data_a_o = rval_a_q ? rdat_a_q : '0;
  assign rd_data_b_o = rval_b_q ? rdat_b_q : '0;

endmodule

// ===== hdl/lsuwb_front.sv =====
// ----------------------------------------------------------------------------
// Load/store unit front end
// Accepts an instruction word, decodes it, reads its registers, forms the
// effective address and the range check, and queues the result.
// ----------------------------------------------------------------------------
module lsuwb_front #(
  parameter int unsigned REG_COUNT = 64,
  parameter int unsigned MEM_BYTES = 65536,
  localparam int unsigned RIW = $clog2(REG_COUNT)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [lsuwb_pkg::ACTION_W-1:0]        action_i,
  input  logic [lsuwb_pkg::FIELD_IDX_W-1:0]     base_reg_i,
  input  logic [lsuwb_pkg::FIELD_IDX_W-1:0]     offset_reg_i,
  input  logic [lsuwb_pkg::FIELD_IDX_W-1:0]     data_reg_i,
  input  logic signed [lsuwb_pkg::DATA_W-1:0]   immediate_i,
  input  logic                                  back_idle_i,
  input  logic                                  q_empty_i,
  input  logic                                  q_full_i,
  output logic                                  q_push_o,
  output lsuwb_pkg::op_t                        q_data_o,
  output logic                                  rf_rd_en_o,
  output logic [RIW-1:0]                        rf_idx_a_o,
  output logic [RIW-1:0]                        rf_idx_b_o,
  input  logic [lsuwb_pkg::DATA_W-1:0]          rf_data_a_i,
  input  logic [lsuwb_pkg::DATA_W-1:0]          rf_data_b_i
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_ADDR = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam logic [lsuwb_pkg::DATA_W-1:0] WordLimit =
    64'(MEM_BYTES - lsuwb_pkg::WORD_BYTES);
  localparam logic [lsuwb_pkg::DATA_W-1:0] ByteLimit = 64'(MEM_BYTES - 1);

  logic [1:0]                           state_q, state_d;
  lsuwb_pkg::op_kind_e                  kind_q, kind_d;
  lsuwb_pkg::addr_mode_e                mode_q, mode_d;
  logic                                 byte_q, byte_d;
  logic [RIW-1:0]                       dat_idx_q;
  logic [lsuwb_pkg::FIELD_IDX_W-1:0]    wr_index_q;
  logic [lsuwb_pkg::DATA_W-1:0]         imm_q;
  logic [lsuwb_pkg::DATA_W-1:0]         addr_q, addr_d;
  logic [RIW-1:0]                       base_red, offr_red, data_red;
  logic [lsuwb_pkg::FIELD_IDX_W-1:0]    data_red6;
  logic                                 accept;
  logic                                 fault;

  // Register fields wrap modulo the register count; a constant lookup.
  always_comb begin
    base_red  = '0;
    offr_red  = '0;
    data_red  = '0;
    data_red6 = '0;
    for (int j = 0; j < 64; j++) begin
      if (base_reg_i == 6'(j)) begin
        base_red = RIW'(j % REG_COUNT);
      end
      if (offset_reg_i == 6'(j)) begin
        offr_red = RIW'(j % REG_COUNT);
      end
      if (data_reg_i == 6'(j)) begin
        data_red  = RIW'(j % REG_COUNT);
        data_red6 = 6'(j % REG_COUNT);
      end
    end
  end

  always_comb begin
    kind_d = lsuwb_pkg::KIND_NONE;
    mode_d = lsuwb_pkg::MODE_REG;
    byte_d = 1'b0;
    case (action_i)
      lsuwb_pkg::ACT_LOAD: begin
        kind_d = lsuwb_pkg::KIND_LOAD;
      end
      lsuwb_pkg::ACT_LOAD_AI: begin
        kind_d = lsuwb_pkg::KIND_LOAD;
        mode_d = lsuwb_pkg::MODE_IMM;
      end
      lsuwb_pkg::ACT_LOAD_AO: begin
        kind_d = lsuwb_pkg::KIND_LOAD;
        mode_d = lsuwb_pkg::MODE_SUM;
      end
      lsuwb_pkg::ACT_CLOAD: begin
        kind_d = lsuwb_pkg::KIND_LOAD;
        byte_d = 1'b1;
      end
      lsuwb_pkg::ACT_CLOAD_AI: begin
        kind_d = lsuwb_pkg::KIND_LOAD;
        mode_d = lsuwb_pkg::MODE_IMM;
        byte_d = 1'b1;
      end
      lsuwb_pkg::ACT_CLOAD_AO: begin
        kind_d = lsuwb_pkg::KIND_LOAD;
        mode_d = lsuwb_pkg::MODE_SUM;
        byte_d = 1'b1;
      end
      lsuwb_pkg::ACT_LOAD_I: begin
        kind_d = lsuwb_pkg::KIND_LOADI;
      end
      lsuwb_pkg::ACT_STORE: begin
        kind_d = lsuwb_pkg::KIND_STORE;
      end
      lsuwb_pkg::ACT_STORE_AI: begin
        kind_d = lsuwb_pkg::KIND_STORE;
        mode_d = lsuwb_pkg::MODE_IMM;
      end
      lsuwb_pkg::ACT_STORE_AO: begin
        kind_d = lsuwb_pkg::KIND_STORE;
        mode_d = lsuwb_pkg::MODE_SUM;
      end
      lsuwb_pkg::ACT_CSTORE: begin
        kind_d = lsuwb_pkg::KIND_STORE;
        byte_d = 1'b1;
      end
      lsuwb_pkg::ACT_CSTORE_AI: begin
        kind_d = lsuwb_pkg::KIND_STORE;
        mode_d = lsuwb_pkg::MODE_IMM;
        byte_d = 1'b1;
      end
      lsuwb_pkg::ACT_CSTORE_AO: begin
        kind_d = lsuwb_pkg::KIND_STORE;
        mode_d = lsuwb_pkg::MODE_SUM;
        byte_d = 1'b1;
      end
      default: begin
        kind_d = lsuwb_pkg::KIND_NONE;
      end
    endcase
  end

  // A new word is taken only when nothing older is still in flight, so the
  // register reads always see every earlier write-back.
  assign in_stall_o = !((state_q == F_IDLE) && q_empty_i && back_idle_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    case (mode_q)
      lsuwb_pkg::MODE_IMM: addr_d = rf_data_a_i + imm_q;
      lsuwb_pkg::MODE_SUM: addr_d = rf_data_a_i + rf_data_b_i;
      default:             addr_d = rf_data_a_i;
    endcase
    if (kind_q == lsuwb_pkg::KIND_NONE || kind_q == lsuwb_pkg::KIND_LOADI) begin
      addr_d = '0;
    end
  end

  assign fault = (kind_q == lsuwb_pkg::KIND_LOAD || kind_q == lsuwb_pkg::KIND_STORE) &&
                 (byte_q ? (addr_q > ByteLimit) : (addr_q > WordLimit));

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_ADDR;
        end
      end
      F_ADDR: begin
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= kind_d;
      mode_q     <= mode_d;
      byte_q     <= byte_d;
      dat_idx_q  <= data_red;
      wr_index_q <= data_red6;
      imm_q      <= $unsigned(immediate_i);
    end
    if (state_q == F_ADDR) begin
      addr_q <= addr_d;
    end
  end

  // Port A reads the base register first and the data register second.
  assign rf_rd_en_o = accept || (state_q == F_ADDR);
  assign rf_idx_a_o = (state_q == F_ADDR) ? dat_idx_q : base_red;
  assign rf_idx_b_o = offr_red;

  assign q_push_o          = (state_q == F_PUSH) && !q_full_i;
  assign q_data_o.kind     = kind_q;
  assign q_data_o.is_byte  = byte_q;
  assign q_data_o.fault    = fault;
  assign q_data_o.rf_idx   = lsuwb_pkg::RF_IDX_W'(dat_idx_q);
  assign q_data_o.wr_index = wr_index_q;
  assign q_data_o.addr     = addr_q;
  assign q_data_o.data     = (kind_q == lsuwb_pkg::KIND_LOADI) ? imm_q : rf_data_a_i;

endmodule

// ===== hdl/lsuwb_queue.sv =====
// ----------------------------------------------------------------------------
// Load/store unit operation queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lsuwb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lsuwb_pkg::op_t  push_data_i,
  input  logic            pop_i,
  output lsuwb_pkg::op_t  head_o,
  output logic            empty_o,
  output logic            full_o
);

  lsuwb_pkg::op_t entries_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           do_push, do_pop;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/lsuwb_back.sv =====
// ----------------------------------------------------------------------------
// Load/store unit back end
// Carries out queued operations one byte per cycle against the byte memory,
// writes loaded values back and holds the result word in an output register.
// ----------------------------------------------------------------------------
module lsuwb_back #(
  parameter int unsigned MEM_BYTES = 65536,
  localparam int unsigned AW = $clog2(MEM_BYTES)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lsuwb_pkg::op_t                       q_data_i,
  input  logic                                 q_empty_i,
  output logic                                 q_pop_o,
  output logic                                 back_idle_o,
  output lsuwb_pkg::rf_wr_t                    rf_wr_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 fault_o,
  output logic                                 reg_written_o,
  output logic [lsuwb_pkg::FIELD_IDX_W-1:0]    written_index_o,
  output logic [lsuwb_pkg::DATA_W-1:0]         written_value_o,
  output logic [lsuwb_pkg::DATA_W-1:0]         access_address_o
);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_MEM   = 2'd1;
  localparam logic [1:0] B_DRAIN = 2'd2;
  localparam logic [1:0] B_DONE  = 2'd3;

  localparam logic [lsuwb_pkg::BYTE_SEL_W-1:0] LastWordByte =
    lsuwb_pkg::BYTE_SEL_W'(lsuwb_pkg::WORD_BYTES - 1);

  logic [7:0]                          mem_q [MEM_BYTES];
  logic [7:0]                          mem_rdata_q;
  logic [1:0]                          state_q, state_d;
  lsuwb_pkg::op_t                      op_q;
  logic [lsuwb_pkg::BYTE_SEL_W-1:0]    cnt_q, rsel_q, last_byte;
  logic                                rpend_q;
  logic [lsuwb_pkg::DATA_W-1:0]        value_q, result_value;
  logic [AW-1:0]                       maddr;
  logic [7:0]                          wbyte;
  logic                                pop, needs_mem, mem_we, mem_re;
  logic                                out_free, retire, wr_ok;
  logic                                out_valid_q, fault_q, reg_written_q;
  logic [lsuwb_pkg::FIELD_IDX_W-1:0]   written_index_q;
  logic [lsuwb_pkg::DATA_W-1:0]        written_value_q, access_address_q;

  assign pop       = (state_q == B_IDLE) && !q_empty_i;
  assign needs_mem = (q_data_i.kind == lsuwb_pkg::KIND_LOAD ||
                      q_data_i.kind == lsuwb_pkg::KIND_STORE) && !q_data_i.fault;
  assign last_byte = op_q.is_byte ? '0 : LastWordByte;
  assign mem_we    = (state_q == B_MEM) && (op_q.kind == lsuwb_pkg::KIND_STORE);
  assign mem_re    = (state_q == B_MEM) && (op_q.kind == lsuwb_pkg::KIND_LOAD);
  assign maddr     = op_q.addr[AW-1:0] + AW'(cnt_q);
  assign wbyte     = 8'(op_q.data >> {cnt_q, 3'b000});
  assign out_free  = !out_valid_q || !out_stall_i;
  assign retire    = (state_q == B_DONE) && out_free;
  assign wr_ok     = !op_q.fault && (op_q.kind == lsuwb_pkg::KIND_LOAD ||
                                     op_q.kind == lsuwb_pkg::KIND_LOADI);
  assign result_value = (op_q.kind == lsuwb_pkg::KIND_LOADI) ? op_q.data : value_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (pop) begin
          state_d = needs_mem ? B_MEM : B_DONE;
        end
      end
      B_MEM: begin
        if (cnt_q == last_byte) begin
          state_d = (op_q.kind == lsuwb_pkg::KIND_LOAD) ? B_DRAIN : B_DONE;
        end
      end
      B_DRAIN: begin
        state_d = B_DONE;
      end
      B_DONE: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      rpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rpend_q <= mem_re;
      if (pop) begin
        cnt_q <= '0;
      end else if (state_q == B_MEM) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (retire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Read data lands in the cycle after its address; merge it into its byte lane.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      op_q    <= q_data_i;
      value_q <= '0;
    end else if (rpend_q) begin
      value_q[{rsel_q, 3'b000} +: 8] <= mem_rdata_q;
    end
    rsel_q <= cnt_q;
    if (retire) begin
      fault_q          <= op_q.fault;
      reg_written_q    <= wr_ok;
      written_index_q  <= wr_ok ? op_q.wr_index : '0;
      written_value_q  <= wr_ok ? result_value : '0;
      access_address_q <= op_q.addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[maddr] <= wbyte;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[maddr];
    end
  end

  assign q_pop_o      = pop;
  assign back_idle_o  = (state_q == B_IDLE);
  assign rf_wr_o.en   = retire && wr_ok;
  assign rf_wr_o.idx  = op_q.rf_idx;
  assign rf_wr_o.data = result_value;

  assign out_valid_o      = out_valid_q;
  assign fault_o          = fault_q;
  assign reg_written_o    = reg_written_q;
  assign written_index_o  = written_index_q;
  assign written_value_o  = written_value_q;
  assign access_address_o = access_address_q;

endmodule

// ===== hdl/lsuwb_checker.sv =====
// ----------------------------------------------------------------------------
// Load/store unit port checker
// Watches the top-level ports of the load/store unit over time.
// ----------------------------------------------------------------------------
module lsuwb_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                fault_o,
  input logic                                reg_written_o,
  input logic [lsuwb_pkg::FIELD_IDX_W-1:0]   written_index_o,
  input logic [lsuwb_pkg::DATA_W-1:0]        written_value_o,
  input logic [lsuwb_pkg::DATA_W-1:0]        access_address_o
);

  // A stalled result word stays offered with its address and value unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(access_address_o) &&
                                   $stable(written_value_o))
    else $error("stalled result word changed");

  // The unit works on one word at a time, so it stalls right after taking one.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a word is still in flight");

  // A faulting access never writes a register.
  a_fault_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o |-> !reg_written_o)
    else $error("faulting access reports a register write");

  // Without a register write the write fields are zero.
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reg_written_o |-> written_index_o == '0 && written_value_o == '0)
    else $error("write fields set without a register write");

endmodule

bind load_store_unit_word_byte lsuwb_checker u_lsuwb_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .fault_o          (fault_o),
  .reg_written_o    (reg_written_o),
  .written_index_o  (written_index_o),
  .written_value_o  (written_value_o),
  .access_address_o (access_address_o)
);
